### design/aabb_vs_rotated_rect_overlap_core_assert.svh
// Assertion macros for the box / rotated rectangle overlap core.
`ifndef AABB_VS_ROTATED_RECT_OVERLAP_CORE_ASSERT_SVH
`define AABB_VS_ROTATED_RECT_OVERLAP_CORE_ASSERT_SVH

// Implication in the same cycle, clocked on clk, quiet in reset.
`define AVR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("overlap core check failed");

// Implication in the next cycle.
`define AVR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("overlap core check failed");

`endif

### design/aabbrr_pkg.sv
package aabbrr_pkg;

	localparam logic [14:0] SINE_ONE = 15'd16384;

	function automatic logic [14:0] sine_tab(input logic [5:0] k);
		logic [14:0] t;
		begin
			case (k)
			6'd0: t = 15'd0;      6'd1: t = 15'd804;    6'd2: t = 15'd1606;
			6'd3: t = 15'd2404;   6'd4: t = 15'd3196;   6'd5: t = 15'd3981;
			6'd6: t = 15'd4756;   6'd7: t = 15'd5520;   6'd8: t = 15'd6270;
			6'd9: t = 15'd7005;   6'd10: t = 15'd7723;  6'd11: t = 15'd8423;
			6'd12: t = 15'd9102;  6'd13: t = 15'd9760;  6'd14: t = 15'd10394;
			6'd15: t = 15'd11003; 6'd16: t = 15'd11585; 6'd17: t = 15'd12140;
			6'd18: t = 15'd12665; 6'd19: t = 15'd13160; 6'd20: t = 15'd13623;
			6'd21: t = 15'd14053; 6'd22: t = 15'd14449; 6'd23: t = 15'd14811;
			6'd24: t = 15'd15137; 6'd25: t = 15'd15426; 6'd26: t = 15'd15679;
			6'd27: t = 15'd15893; 6'd28: t = 15'd16069; 6'd29: t = 15'd16207;
			6'd30: t = 15'd16305; 6'd31: t = 15'd16364;
			default: t = 15'd16384;
			endcase
			return t;
		end
	endfunction

	// quarter-wave sine, x in 0..16384, linear interpolation between table points
	function automatic logic [14:0] quarter_sine(input logic [14:0] x);
		logic [5:0] k;
		logic [14:0] t0;
		logic [14:0] t1;
		logic [9:0] dt;
		logic [19:0] prod;
		begin
			k = {1'b0, x[13:9]};
			t0 = sine_tab(k);
			t1 = sine_tab(k + 6'd1);
			dt = 10'(t1 - t0);
			prod = 20'(dt) * 20'(x[8:0]) + 20'd256;
			if (x[14])
				return SINE_ONE;
			return t0 + 15'(prod[19:9]);
		end
	endfunction

endpackage

### design/aabb_vs_rotated_rect_overlap_core.sv
// Box versus rotated rectangle overlap core (separating axis test).
// Input channel: in_valid / in_stall carry one request: an axis-aligned box
// (left, top, width, height) and a rectangle (centre, full width, full height,
// turn_angle in 1/2^ANGLE_BITS of a turn). Coordinates are signed Q16.8.
// Output channel: out_valid / out_stall carry collides, high when no axis
// separates the shapes; touching counts as overlap.
// Each accepted request passes the stage registers s1 to s5 in turn, and
// out_valid is vld_s5. Throughput: one request per cycle while no result is
// stalled, set by the five-stage pipeline (sine lookup, products, sums,
// size-by-norm products with box-axis compares, rectangle-axis compares).
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; payload registers are left as they are.
module aabb_vs_rotated_rect_overlap_core #(
	parameter int ANGLE_BITS = 12,
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  box_left,
	input  logic signed [COORD_BITS-1:0]  box_top,
	input  logic        [COORD_BITS-2:0]  box_width,
	input  logic        [COORD_BITS-2:0]  box_height,
	input  logic signed [COORD_BITS-1:0]  rect_center_x,
	input  logic signed [COORD_BITS-1:0]  rect_center_y,
	input  logic        [COORD_BITS-2:0]  rect_width,
	input  logic        [COORD_BITS-2:0]  rect_height,
	input  logic        [ANGLE_BITS-1:0]  turn_angle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          collides
);
	import aabbrr_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int W  = COORD_BITS + 40;
	localparam logic signed [CW+15:0] PZERO = '0;

	// advance the whole pipeline unless a finished result is held back
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage 1: sine and cosine, centre offsets from the box corner
	logic [15:0] phase;
	logic [14:0] su, sv;
	logic signed [15:0] sn_c, cs_c;
	always_comb begin
		phase = 16'(turn_angle) << (16 - ANGLE_BITS);
		su = quarter_sine({1'b0, phase[13:0]});
		sv = quarter_sine(SINE_ONE - {1'b0, phase[13:0]});
		case (phase[15:14])
		2'd0: begin sn_c = $signed({1'b0, su});  cs_c = $signed({1'b0, sv});  end
		2'd1: begin sn_c = $signed({1'b0, sv});  cs_c = -$signed({1'b0, su}); end
		2'd2: begin sn_c = -$signed({1'b0, su}); cs_c = -$signed({1'b0, sv}); end
		default: begin sn_c = -$signed({1'b0, sv}); cs_c = $signed({1'b0, su}); end
		endcase
	end

	logic signed [15:0] sn_s1, cs_s1;
	logic signed [CW:0] dx_s1, dy_s1;
	logic [CW-2:0] bw_s1, bh_s1, rw_s1, rh_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			sn_s1 <= sn_c;
			cs_s1 <= cs_c;
			dx_s1 <= (CW+1)'(rect_center_x) - (CW+1)'(box_left);
			dy_s1 <= (CW+1)'(rect_center_y) - (CW+1)'(box_top);
			bw_s1 <= box_width;
			bh_s1 <= box_height;
			rw_s1 <= rect_width;
			rh_s1 <= rect_height;
		end
	end

	// stage 2: all products by sine and cosine
	logic [14:0] acs, asn;
	assign acs = 15'(cs_s1 < 0 ? -cs_s1 : cs_s1);
	assign asn = 15'(sn_s1 < 0 ? -sn_s1 : sn_s1);

	logic [CW+13:0] exa_s2, exb_s2, eya_s2, eyb_s2;
	logic signed [CW+16:0] dxc_s2, dys_s2, dxs_s2, dyc_s2;
	logic signed [CW+15:0] bwc_s2, bhs_s2, bws_s2, bhc_s2;
	logic signed [31:0] css_s2, sns_s2;
	logic signed [CW:0] dx_s2, dy_s2;
	logic [CW-2:0] bw_s2, bh_s2, rw_s2, rh_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			exa_s2 <= rw_s1 * acs;
			exb_s2 <= rh_s1 * asn;
			eya_s2 <= rw_s1 * asn;
			eyb_s2 <= rh_s1 * acs;
			dxc_s2 <= dx_s1 * cs_s1;
			dys_s2 <= dy_s1 * sn_s1;
			dxs_s2 <= dx_s1 * sn_s1;
			dyc_s2 <= dy_s1 * cs_s1;
			bwc_s2 <= $signed({1'b0, bw_s1}) * cs_s1;
			bhs_s2 <= $signed({1'b0, bh_s1}) * sn_s1;
			bws_s2 <= $signed({1'b0, bw_s1}) * sn_s1;
			bhc_s2 <= $signed({1'b0, bh_s1}) * cs_s1;
			css_s2 <= cs_s1 * cs_s1;
			sns_s2 <= sn_s1 * sn_s1;
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			bw_s2 <= bw_s1;
			bh_s2 <= bh_s1;
			rw_s2 <= rw_s1;
			rh_s2 <= rh_s1;
		end
	end

	// stage 3: extents, centre projections, box ranges, squared norm
	logic signed [CW+15:0] nbws;
	logic signed [CW+16:0] m2_c, mx2_c, m3_c, mx3_c;
	always_comb begin
		nbws = -bws_s2;
		m2_c  = (CW+17)'(bwc_s2 < 0 ? bwc_s2 : PZERO) +
			(CW+17)'(bhs_s2 < 0 ? bhs_s2 : PZERO);
		mx2_c = (CW+17)'(bwc_s2 > 0 ? bwc_s2 : PZERO) +
			(CW+17)'(bhs_s2 > 0 ? bhs_s2 : PZERO);
		m3_c  = (CW+17)'(nbws < 0 ? nbws : PZERO) +
			(CW+17)'(bhc_s2 < 0 ? bhc_s2 : PZERO);
		mx3_c = (CW+17)'(nbws > 0 ? nbws : PZERO) +
			(CW+17)'(bhc_s2 > 0 ? bhc_s2 : PZERO);
	end

	logic [CW+14:0] ex_s3, ey_s3;
	logic signed [CW+17:0] d2_s3, d3_s3;
	logic signed [CW+16:0] m2_s3, mx2_s3, m3_s3, mx3_s3;
	logic [29:0] n_s3;
	logic signed [CW:0] dx_s3, dy_s3;
	logic [CW-2:0] bw_s3, bh_s3, rw_s3, rh_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s3 <= (CW+15)'(exa_s2) + (CW+15)'(exb_s2);
			ey_s3 <= (CW+15)'(eya_s2) + (CW+15)'(eyb_s2);
			d2_s3 <= (CW+18)'(dxc_s2) + (CW+18)'(dys_s2);
			d3_s3 <= (CW+18)'(dyc_s2) - (CW+18)'(dxs_s2);
			m2_s3 <= m2_c;
			mx2_s3 <= mx2_c;
			m3_s3 <= m3_c;
			mx3_s3 <= mx3_c;
			n_s3 <= 30'(css_s2) + 30'(sns_s2);
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			bw_s3 <= bw_s2;
			bh_s3 <= bh_s2;
			rw_s3 <= rw_s2;
			rh_s3 <= rh_s2;
		end
	end

	// stage 4: box axes decided; rectangle half sizes scaled by the norm
	logic signed [W-1:0] exw, eyw, dxw, dyw;
	logic ok0_c, ok1_c;
	always_comb begin
		exw = $signed(W'(ex_s3));
		eyw = $signed(W'(ey_s3));
		dxw = W'(dx_s3);
		dyw = W'(dy_s3);
		ok0_c = (-(dxw <<< 15) <= exw) &&
			(((dxw - $signed(W'(bw_s3))) <<< 15) <= exw);
		ok1_c = (-(dyw <<< 15) <= eyw) &&
			(((dyw - $signed(W'(bh_s3))) <<< 15) <= eyw);
	end

	logic [CW+28:0] rwn_s4, rhn_s4;
	logic signed [W-1:0] a2_s4, b2_s4, a3_s4, b3_s4;
	logic ok01_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			rwn_s4 <= rw_s3 * n_s3;
			rhn_s4 <= rh_s3 * n_s3;
			a2_s4 <= (W'(m2_s3) - W'(d2_s3)) <<< 15;
			b2_s4 <= (W'(d2_s3) - W'(mx2_s3)) <<< 15;
			a3_s4 <= (W'(m3_s3) - W'(d3_s3)) <<< 15;
			b3_s4 <= (W'(d3_s3) - W'(mx3_s3)) <<< 15;
			ok01_s4 <= ok0_c && ok1_c;
		end
	end

	// stage 5: rectangle axes decided, result out
	logic signed [W-1:0] rwnw, rhnw;
	assign rwnw = $signed(W'(rwn_s4));
	assign rhnw = $signed(W'(rhn_s4));

	logic hit_s5;
	always_ff @(posedge clk) begin
		if (adv)
			hit_s5 <= ok01_s4 && (a2_s4 <= rwnw) && (b2_s4 <= rwnw) &&
				(a3_s4 <= rhnw) && (b3_s4 <= rhnw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign out_valid = vld_s5;
	assign collides = hit_s5;

	`include "aabb_vs_rotated_rect_overlap_core_assert.svh"

	// an accepted request always lands in stage one
	`AVR_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, vld_s1)
	// a held pipeline keeps every valid bit
	`AVR_ASSERT_NEXT(a_hold_valids, !adv, $stable({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5}))
	// zero angle gives unit cosine and zero sine
	`AVR_ASSERT_NEXT(a_zero_angle, in_valid && !in_stall && turn_angle == '0,
		sn_s1 == 16'sd0 && cs_s1 == 16'sd16384)

endmodule
